FILE: hdl/sfr_pkg.sv
package sfr_pkg;

  // request selector carried on the input tuser
  typedef enum logic [1:0] {
    MODE_RX    = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  // configuration register indexes
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_HEADER = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_EXTRA  = 1'd1;

  // register reset values
  localparam logic [7:0] HEADER_RESET = 8'hA0;
  localparam logic [7:0] EXTRA_RESET  = 8'd7;

  // line end characters
  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  // byte counter and frame length widths
  localparam int CNT_W = 14;
  localparam int TOT_W = 17;

  // result buffer sizing
  localparam int OUT_DEPTH = 3;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int LVL_W     = $clog2(OUT_DEPTH + 1);

  // one result item
  typedef struct packed {
    logic [7:0] read_data;
    logic       restarted;
    logic       cr_seen;
    logic       binary_frame;
    logic       frame_done;
    logic [8:0] frame_count;
  } result_t;

endpackage

FILE: hdl/sfr_out_fifo.sv
module sfr_out_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sfr_pkg::result_t      push_data,
  input  logic                  pop_ready,
  output logic                  pop_valid,
  output sfr_pkg::result_t      pop_data,
  output logic [sfr_pkg::LVL_W-1:0] level
);
  import sfr_pkg::*;

  result_t            entries [OUT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic               pop;

  assign pop_valid = (level != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hdl/serial_frame_receiver_unit.sv
// Serial frame receiver.
// Input stream: s_tuser carries the request mode (receive byte, read buffer
// entry, clear status); s_tdata carries the received byte and the read index.
// Every request gives exactly one result on the output stream, in order,
// with the frame status after the request and the read data for reads.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_index
// (header byte, length extra) at once; write it only while no request is
// in flight.
// Results are registered in the first result stage and then written into
// the result buffer, whose output drives the master stream.
// Throughput: one request per cycle while s_tready is high. The frame
// buffer is a registered-read synchronous RAM with one write and one
// read port; receives write, reads read: no request needs both ports or forwarding.
// Results pass through a three-entry buffer; when the downstream stalls,
// up to three results are held and then s_tready falls until space frees.
// Reset clears the frame status and the registers to their defaults; the
// frame buffer contents are not cleared and no request may read an entry
// that was never written.
module serial_frame_receiver_unit #(
  parameter int BUF_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  // slave stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // rx_byte[7:0], read_index[15:8]
  input  logic [1:0]                    s_tuser,   // mode[1:0]
  // master stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,   // frame_count[8:0], frame_done[9],
                                                   // binary_frame[10], cr_seen[11],
                                                   // restarted[12], read_data[20:13],
                                                   // zero[23:21]
  // configuration write port
  input  logic                          cfg_we,
  input  logic [sfr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata
);
  import sfr_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUF_DEPTH);

  // configuration registers
  logic [7:0] header_byte;
  logic [7:0] length_extra;

  // frame status
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             done_flag, done_flag_next;
  logic             cr_flag, cr_flag_next;
  logic [7:0]       first_byte, first_byte_next;
  logic [7:0]       length_high, length_high_next;
  logic [7:0]       length_low, length_low_next;

  // frame buffer
  logic [7:0]       frame_store [BUF_DEPTH];
  logic [7:0]       rd_word;

  // request fields
  logic             accept;
  mode_t            mode;
  logic [7:0]       rx_byte;
  logic [7:0]       read_index;

  // update terms
  logic [CNT_W-1:0] cnt_inc;
  logic             bin_sel;
  logic [7:0]       lh_w;
  logic [7:0]       ll_w;
  logic [TOT_W-1:0] total;
  logic             restart;
  logic             wr_req;
  logic [CNT_W-1:0] wr_idx;
  logic             wr_en;
  logic             rd_en;

  // first result stage
  logic             s1_valid;
  result_t          s1_res;
  logic             s1_rd_ok;
  result_t          push_data;

  // buffer side
  result_t          out_res;
  logic [LVL_W-1:0] out_level;
  logic [LVL_W:0]   used;

  assign accept     = s_tvalid && s_tready;
  assign mode       = mode_t'(s_tuser);
  assign rx_byte    = s_tdata[7:0];
  assign read_index = s_tdata[15:8];

  assign used     = (LVL_W + 1)'(out_level) + (LVL_W + 1)'(s1_valid);
  assign s_tready = (used < (LVL_W + 1)'(OUT_DEPTH));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte  <= HEADER_RESET;
      length_extra <= EXTRA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER: header_byte  <= cfg_wdata;
        REG_EXTRA:  length_extra <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // frame kind and length as seen by a binary byte written at byte_count
  assign cnt_inc = byte_count + 1'b1;
  assign bin_sel = (byte_count == '0) ? (rx_byte == header_byte)
                                      : (first_byte == header_byte);
  assign lh_w    = (byte_count == CNT_W'(2)) ? rx_byte : length_high;
  assign ll_w    = (byte_count == CNT_W'(3)) ? rx_byte : length_low;
  assign total   = TOT_W'({lh_w, ll_w}) + TOT_W'(length_extra);

  // next frame status
  always_comb begin
    byte_count_next  = byte_count;
    done_flag_next   = done_flag;
    cr_flag_next     = cr_flag;
    first_byte_next  = first_byte;
    length_high_next = length_high;
    length_low_next  = length_low;
    restart          = 1'b0;
    wr_req           = 1'b0;
    wr_idx           = byte_count;
    rd_en            = 1'b0;
    unique case (mode)
      MODE_RX: begin
        if (done_flag) begin
          // new frame after a completed one
          done_flag_next  = 1'b0;
          cr_flag_next    = 1'b0;
          wr_req          = 1'b1;
          wr_idx          = '0;
          byte_count_next = CNT_W'(1);
        end else if (bin_sel) begin
          // length-field frame
          wr_req          = 1'b1;
          byte_count_next = cnt_inc;
          if (cnt_inc >= CNT_W'(4)) begin
            if (cr_flag || cnt_inc >= DEPTH_C) begin
              byte_count_next = '0;
              cr_flag_next    = 1'b0;
              restart         = 1'b1;
            end
            if (TOT_W'(byte_count_next) == total) begin
              done_flag_next = 1'b1;
            end
          end
        end else if (cr_flag) begin
          // expect lf after cr
          if (rx_byte != CHAR_LF) begin
            byte_count_next = '0;
            cr_flag_next    = 1'b0;
            restart         = 1'b1;
          end else begin
            wr_req         = 1'b1;
            done_flag_next = 1'b1;
          end
        end else if (rx_byte == CHAR_CR) begin
          cr_flag_next    = 1'b1;
          wr_req          = 1'b1;
          byte_count_next = cnt_inc;
        end else begin
          // ordinary text byte, restart on overflow
          wr_req          = 1'b1;
          byte_count_next = cnt_inc;
          if (cnt_inc >= DEPTH_C) begin
            byte_count_next = '0;
            restart         = 1'b1;
          end
        end
      end
      MODE_READ: begin
        rd_en = (CNT_W'(read_index) < DEPTH_C);
      end
      MODE_CLEAR: begin
        if (byte_count != '0) begin
          byte_count_next = '0;
          done_flag_next  = 1'b0;
          cr_flag_next    = 1'b0;
        end
      end
      default: ;
    endcase

    // shadow copies of entries 0, 2 and 3
    wr_en = wr_req && (wr_idx < DEPTH_C);
    if (wr_en) begin
      if (wr_idx == CNT_W'(0)) first_byte_next  = rx_byte;
      if (wr_idx == CNT_W'(2)) length_high_next = rx_byte;
      if (wr_idx == CNT_W'(3)) length_low_next  = rx_byte;
    end
  end

  // frame status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      done_flag   <= 1'b0;
      cr_flag     <= 1'b0;
      first_byte  <= '0;
      length_high <= '0;
      length_low  <= '0;
    end else if (accept) begin
      byte_count  <= byte_count_next;
      done_flag   <= done_flag_next;
      cr_flag     <= cr_flag_next;
      first_byte  <= first_byte_next;
      length_high <= length_high_next;
      length_low  <= length_low_next;
    end
  end

  // frame buffer ram, registered read
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      frame_store[wr_idx[AW-1:0]] <= rx_byte;
    end
    if (accept && rd_en) begin
      rd_word <= frame_store[AW'(read_index)];
    end
  end

  // first result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res.frame_count  <= byte_count_next[8:0];
      s1_res.frame_done   <= done_flag_next;
      s1_res.binary_frame <= (byte_count_next != '0) && (first_byte_next == header_byte);
      s1_res.cr_seen      <= cr_flag_next;
      s1_res.restarted    <= restart;
      s1_res.read_data    <= '0;
      s1_rd_ok            <= rd_en;
    end
  end

  always_comb begin
    push_data           = s1_res;
    push_data.read_data = s1_rd_ok ? rd_word : 8'd0;
  end

  // result buffer
  sfr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (push_data),
    .pop_ready (m_tready),
    .pop_valid (m_tvalid),
    .pop_data  (out_res),
    .level     (out_level)
  );

  assign m_tdata = {3'b000, out_res};

endmodule
